/* src/chacha20_stream_cipher_unit_defines.svh */
// assertion macros for the checker file of the stream cipher unit
`ifndef CHACHA20_STREAM_CIPHER_UNIT_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CC20_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cc20 check failed in the same cycle");

// consequent must hold in the cycle after the antecedent
`define CC20_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cc20 check failed one cycle later");

`endif

/* src/cc20_pkg.sv */
// shared types, constants and helpers of the chacha20 stream cipher unit
package cc20_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned CFG_W    = 64;
    localparam int unsigned ADDR_W   = 6;
    localparam int unsigned KS_DEPTH = 8;
    localparam int unsigned KS_AW    = 3;

    // "expand 32-byte k"
    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

    // register indexes (byte address 8*index)
    localparam logic [2:0] REG_KEY_0    = 3'd0;
    localparam logic [2:0] REG_KEY_1    = 3'd1;
    localparam logic [2:0] REG_KEY_2    = 3'd2;
    localparam logic [2:0] REG_KEY_3    = 3'd3;
    localparam logic [2:0] REG_NONCE_LO = 3'd4;
    localparam logic [2:0] REG_NONCE_HI = 3'd5;
    localparam logic [2:0] REG_INIT_CTR = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_LOAD,
        S_STEP,
        S_STORE,
        S_FEED,
        S_READ,
        S_PUT
    } t_state;

    // quarter-round steps, each with its own rotation
    typedef enum logic [1:0] {
        STEP_R16,
        STEP_R12,
        STEP_R8,
        STEP_R7
    } t_step;

    // state index of member (a, b, c, d) of a quarter round in a column or diagonal round
    function automatic logic [3:0] qr_index(input logic diag, input logic [1:0] lane,
                                            input logic [1:0] member);
        logic [1:0] off;
        off = lane + (diag ? member : 2'd0);
        return {member, off};
    endfunction

endpackage

/* src/cc20_if.sv */
// valid/ready channels for data words in and result words out
interface cc20_in_if;
    import cc20_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_in;
    logic              restart;

    modport source (output valid, output data_in, output restart, input ready);
    modport sink   (input valid, input data_in, input restart, output ready);
endinterface

interface cc20_out_if;
    import cc20_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              block_end;

    modport source (output valid, output data_out, output block_end, input ready);
    modport sink   (input valid, input data_out, input block_end, output ready);
endinterface

/* src/chacha20_stream_cipher_unit.sv */
// ChaCha20 (IETF, 96-bit nonce) stream cipher unit: top level.
// Each accepted 64-bit word is XORed with the keystream bytes at its place in the
// current 64-byte block and comes out with block_end set on the eighth word. The
// first word of a block (or any word with restart set) first builds the block's
// keystream: the initial state is loaded into the working words, then every quarter
// round runs as 4 loads, 4 add-xor-rotate steps and 4 stores through one shared step
// unit, four quarter rounds per round, and the initial state is added back into an
// 8 x 64 keystream ram. No new word is taken until that word's result is registered;
// each of the other seven words is read from the keystream ram and registered as a
// result before the next word can be taken. The result register lets a new word be
// accepted while the last result waits. Key, nonce and initial counter are to be
// written over the apb port only while the unit is idle; the unit does not enforce
// this. Registers use 64-bit slots at byte address 8*index, writes beyond are dropped.
module chacha20_stream_cipher_unit #(
    parameter int unsigned ROUND_COUNT = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cc20_pkg::ADDR_W-1:0] paddr,
    input  logic [cc20_pkg::CFG_W-1:0]  pwdata,
    output logic [cc20_pkg::CFG_W-1:0]  prdata,
    output logic                        pready,
    cc20_in_if.sink                     i_data_ch,
    cc20_out_if.source                  o_result_ch
);
    import cc20_pkg::*;

    localparam int unsigned RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);
    localparam logic [3:0] CNT_LAST_WORD   = 4'd15;
    localparam logic [3:0] CNT_LAST_MEMBER = 4'd3;
    localparam logic [1:0] LAST_LANE       = 2'd3;
    localparam logic [2:0] LAST_POS        = 3'd7;

    // configuration registers
    logic [CFG_W-1:0]  r_key_0, r_key_1, r_key_2, r_key_3, r_nonce_lo;
    logic [WORD_W-1:0] r_nonce_hi, r_init_ctr;

    // sequencer and stream position
    t_state            r_state, n_state;
    logic [3:0]        r_cnt;
    logic [1:0]        r_lane;
    logic [RW-1:0]     r_round;
    logic [WORD_W-1:0] r_counter;
    logic [2:0]        r_pos;
    logic [2:0]        r_item_pos;

    // working state and quarter-round operands
    logic [WORD_W-1:0] r_work [16];
    logic [WORD_W-1:0] r_qa, r_qb, r_qc, r_qd;
    logic [WORD_W-1:0] r_lo;
    logic [DATA_W-1:0] r_data;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_end;

    logic              cfg_wr;
    logic [2:0]        cfg_idx;
    logic              in_ready, in_acc;
    logic [2:0]        eff_pos;
    logic              out_load;
    logic [WORD_W-1:0] w_init [16];
    logic [3:0]        qr_idx;
    logic [WORD_W-1:0] work_rd;
    logic              work_we;
    logic [3:0]        work_widx;
    logic [WORD_W-1:0] work_wd;
    logic [WORD_W-1:0] st_x, st_y, st_z, st_sum, st_mix;
    t_step             st_step;
    logic              ram_we, ram_re;
    logic [DATA_W-1:0] ram_rdata;

    // apb decode
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            REG_KEY_0:    prdata = r_key_0;
            REG_KEY_1:    prdata = r_key_1;
            REG_KEY_2:    prdata = r_key_2;
            REG_KEY_3:    prdata = r_key_3;
            REG_NONCE_LO: prdata = r_nonce_lo;
            REG_NONCE_HI: prdata = {{(CFG_W-WORD_W){1'b0}}, r_nonce_hi};
            REG_INIT_CTR: prdata = {{(CFG_W-WORD_W){1'b0}}, r_init_ctr};
            default:      prdata = '0;
        endcase
    end

    // initial block state: constants, key, counter, nonce
    always_comb begin
        w_init[0]  = SIGMA_0;
        w_init[1]  = SIGMA_1;
        w_init[2]  = SIGMA_2;
        w_init[3]  = SIGMA_3;
        w_init[4]  = r_key_0[31:0];
        w_init[5]  = r_key_0[63:32];
        w_init[6]  = r_key_1[31:0];
        w_init[7]  = r_key_1[63:32];
        w_init[8]  = r_key_2[31:0];
        w_init[9]  = r_key_2[63:32];
        w_init[10] = r_key_3[31:0];
        w_init[11] = r_key_3[63:32];
        w_init[12] = r_counter;
        w_init[13] = r_nonce_lo[31:0];
        w_init[14] = r_nonce_lo[63:32];
        w_init[15] = r_nonce_hi;
    end

    // handshake
    assign in_ready = (r_state == S_IDLE);
    assign in_acc   = i_data_ch.valid && in_ready;
    assign eff_pos  = i_data_ch.restart ? 3'd0 : r_pos;
    assign out_load = (r_state == S_PUT) && (!r_out_valid || o_result_ch.ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (eff_pos == 3'd0) ? S_INIT : S_READ;
                end
            end
            S_INIT: begin
                if (r_cnt == CNT_LAST_WORD) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_cnt == CNT_LAST_MEMBER) n_state = S_STEP;
            end
            S_STEP: begin
                if (r_cnt == CNT_LAST_MEMBER) n_state = S_STORE;
            end
            S_STORE: begin
                if (r_cnt == CNT_LAST_MEMBER) begin
                    if (r_lane == LAST_LANE && r_round == LAST_ROUND) begin
                        n_state = S_FEED;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_FEED: begin
                if (r_cnt == CNT_LAST_WORD) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_PUT;
            end
            S_PUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb begin
        qr_idx    = qr_index(r_round[0], r_lane, r_cnt[1:0]);
        work_rd   = r_work[(r_state == S_FEED) ? r_cnt : qr_idx];
        work_we   = 1'b0;
        work_widx = r_cnt;
        work_wd   = w_init[r_cnt];
        st_x      = r_qa;
        st_y      = r_qb;
        st_z      = r_qd;
        st_step   = STEP_R16;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        case (r_state)
            S_INIT: begin
                work_we = 1'b1;
            end
            S_STEP: begin
                st_step = t_step'(r_cnt[1:0]);
                if (r_cnt[0]) begin
                    st_x = r_qc;
                    st_y = r_qd;
                    st_z = r_qb;
                end
            end
            S_STORE: begin
                work_we   = 1'b1;
                work_widx = qr_idx;
                work_wd   = r_qa;
            end
            S_FEED: begin
                st_x   = work_rd;
                st_y   = w_init[r_cnt];
                st_z   = '0;
                ram_we = r_cnt[0];
            end
            S_READ: begin
                ram_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    cc20_qstep u_qstep (
        .i_x    (st_x),
        .i_y    (st_y),
        .i_z    (st_z),
        .i_step (st_step),
        .o_sum  (st_sum),
        .o_mix  (st_mix)
    );

    // keystream, one 64-bit entry per data word
    cc20_ram #(
        .WIDTH (DATA_W),
        .DEPTH (KS_DEPTH)
    ) u_ks_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[3:1]),
        .i_wdata ({st_sum, r_lo}),
        .i_re    (ram_re),
        .i_raddr (r_item_pos),
        .o_rdata (ram_rdata)
    );

    // control registers, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_lane      <= '0;
            r_round     <= '0;
            r_counter   <= '0;
            r_pos       <= '0;
            r_item_pos  <= '0;
            r_out_valid <= 1'b0;
            r_key_0     <= '0;
            r_key_1     <= '0;
            r_key_2     <= '0;
            r_key_3     <= '0;
            r_nonce_lo  <= '0;
            r_nonce_hi  <= '0;
            r_init_ctr  <= '0;
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                case (cfg_idx)
                    REG_KEY_0:    r_key_0    <= pwdata;
                    REG_KEY_1:    r_key_1    <= pwdata;
                    REG_KEY_2:    r_key_2    <= pwdata;
                    REG_KEY_3:    r_key_3    <= pwdata;
                    REG_NONCE_LO: r_nonce_lo <= pwdata;
                    REG_NONCE_HI: r_nonce_hi <= pwdata[WORD_W-1:0];
                    REG_INIT_CTR: r_init_ctr <= pwdata[WORD_W-1:0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (in_acc) begin
                        r_item_pos <= eff_pos;
                        if (i_data_ch.restart) r_counter <= r_init_ctr;
                    end
                end
                S_INIT: begin
                    r_cnt   <= r_cnt + 4'd1;
                    r_lane  <= '0;
                    r_round <= '0;
                end
                S_LOAD, S_STEP: begin
                    r_cnt <= (r_cnt == CNT_LAST_MEMBER) ? 4'd0 : r_cnt + 4'd1;
                end
                S_STORE: begin
                    r_cnt <= (r_cnt == CNT_LAST_MEMBER) ? 4'd0 : r_cnt + 4'd1;
                    if (r_cnt == CNT_LAST_MEMBER) begin
                        r_lane <= r_lane + 2'd1;
                        if (r_lane == LAST_LANE) r_round <= r_round + RW'(1);
                    end
                end
                S_FEED: begin
                    r_cnt <= r_cnt + 4'd1;
                end
                S_READ: begin
                    r_pos <= r_item_pos + 3'd1;
                    if (r_item_pos == LAST_POS) r_counter <= r_counter + 32'd1;
                end
                default: begin
                end
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_data <= i_data_ch.data_in;
        end
        if (work_we) begin
            r_work[work_widx] <= work_wd;
        end
        case (r_state)
            S_LOAD: begin
                {r_qa, r_qb, r_qc, r_qd} <= {r_qb, r_qc, r_qd, work_rd};
            end
            S_STEP: begin
                if (r_cnt[0]) begin
                    r_qc <= st_sum;
                    r_qb <= st_mix;
                end else begin
                    r_qa <= st_sum;
                    r_qd <= st_mix;
                end
            end
            S_STORE: begin
                {r_qa, r_qb, r_qc, r_qd} <= {r_qb, r_qc, r_qd, r_qa};
            end
            S_FEED: begin
                if (!r_cnt[0]) r_lo <= st_sum;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_data <= r_data ^ ram_rdata;
            r_out_end  <= (r_item_pos == LAST_POS);
        end
    end

    // channel outputs
    assign i_data_ch.ready       = in_ready;
    assign o_result_ch.valid     = r_out_valid;
    assign o_result_ch.data_out  = r_out_data;
    assign o_result_ch.block_end = r_out_end;

endmodule

/* src/cc20_ram.sv */
// generic single-write, single-read ram with registered read data
module cc20_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/cc20_qstep.sv */
// shared add-xor-rotate unit: one quarter-round step per use
module cc20_qstep (
    input  logic [cc20_pkg::WORD_W-1:0] i_x,
    input  logic [cc20_pkg::WORD_W-1:0] i_y,
    input  logic [cc20_pkg::WORD_W-1:0] i_z,
    input  cc20_pkg::t_step             i_step,
    output logic [cc20_pkg::WORD_W-1:0] o_sum,
    output logic [cc20_pkg::WORD_W-1:0] o_mix
);
    import cc20_pkg::*;

    logic [WORD_W-1:0] w_xor;

    // x + y, then (z ^ sum) rotated left by the step's amount
    assign o_sum = i_x + i_y;
    assign w_xor = i_z ^ o_sum;

    always_comb begin
        case (i_step)
            STEP_R16: o_mix = {w_xor[15:0], w_xor[31:16]};
            STEP_R12: o_mix = {w_xor[19:0], w_xor[31:20]};
            STEP_R8:  o_mix = {w_xor[23:0], w_xor[31:24]};
            STEP_R7:  o_mix = {w_xor[24:0], w_xor[31:25]};
            default:  o_mix = w_xor;
        endcase
    end

endmodule

/* src/cc20_checker.sv */
// port-level checks of the stream cipher unit and their bind
`include "chacha20_stream_cipher_unit_defines.svh"

module cc20_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [cc20_pkg::DATA_W-1:0] i_out_data,
    input logic                        i_out_end
);
    import cc20_pkg::*;

    // a taken word keeps the unit busy for at least the next cycle
    `CC20_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // a stalled result word holds
    `CC20_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data) && $stable(i_out_end))

    // a result never appears right after its word is taken
    `CC20_ASSERT_NOW(a_no_instant_result, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_valid && i_in_ready))

endmodule

bind chacha20_stream_cipher_unit cc20_checker u_cc20_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_data_ch.valid),
    .i_in_ready  (i_data_ch.ready),
    .i_out_valid (o_result_ch.valid),
    .i_out_ready (o_result_ch.ready),
    .i_out_data  (o_result_ch.data_out),
    .i_out_end   (o_result_ch.block_end)
);
